/* rtl/u2u8_pkg.sv */
// shared types and constants for the utf-16 to utf-8 encoder
// no dependencies
`default_nettype none

package u2u8_pkg;

  localparam int unsigned MAX_BYTES = 5;
  localparam int unsigned COUNT_W   = 3;

  localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [15:0] HIGH_SURR_LO   = 16'hd800;
  localparam logic [15:0] HIGH_SURR_HI   = 16'hdbff;
  // 0x10000 - 0xdc00, the high base is removed by keeping only its low ten bits
  localparam logic [20:0] PAIR_OFFSET    = 21'h02400;

  typedef enum logic [2:0] {
    CLS_ONE,
    CLS_TWO,
    CLS_THREE,
    CLS_HOLD,
    CLS_PAIR
  } unit_class_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [COUNT_W-1:0]        count;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

endpackage

`default_nettype wire

/* rtl/u2u8_if.sv */
// channel interfaces for code units in and utf-8 bytes out
// no dependencies
`default_nettype none

interface u2u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        is_last;

  modport source (output valid, output code_unit, output is_last, input ready);
  modport sink (input valid, input code_unit, input is_last, output ready);
endinterface

interface u2u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/utf16_to_utf8_encoder_unit.sv */
// utf-16 to utf-8 encoder top level
// path: an accepted unit goes to the queue, then the back end's list register, then output register
// throughput: one byte per cycle while the receiver is ready, set by the single byte-wide output
//   register; a unit has up to 5 bytes with the terminator, a held high surrogate has none
// reset: drops any pending high surrogate, empties the queue and the output register
// depends on u2u8_pkg, u2u8_if, u2u8_front, u2u8_queue, u2u8_back
`default_nettype none

module utf16_to_utf8_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  u2u8_in_if.sink      in_ch,
  u2u8_out_if.source   out_ch
);

  u2u8_pkg::push_t   push;
  u2u8_pkg::entry_t  head;
  logic              q_full, q_valid, q_pop;

  u2u8_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push_o (push)
  );

  u2u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  u2u8_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

/* rtl/u2u8_front.sv */
// front end: accepts code units, tracks a pending high surrogate, builds byte lists
// depends on u2u8_pkg and u2u8_in_if
`default_nettype none

module u2u8_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  u2u8_in_if.sink            in_ch,
  input  wire logic          q_full,
  output u2u8_pkg::push_t    push_o
);

  logic                   held_r, held_nxt;
  logic [9:0]             held_unit_r, held_unit_nxt;
  logic                   accept;
  u2u8_pkg::unit_class_t  cls;
  logic [20:0]            cp;
  logic [15:0]            u;
  u2u8_pkg::entry_t       entry;

  assign u           = in_ch.code_unit;
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign cp          = {1'b0, held_unit_r, 10'b0} + {5'b0, u} + u2u8_pkg::PAIR_OFFSET;

  always_comb begin
    if (held_r) begin
      cls = u2u8_pkg::CLS_PAIR;
    end else if (u < u2u8_pkg::ONE_BYTE_LIMIT) begin
      cls = u2u8_pkg::CLS_ONE;
    end else if (u < u2u8_pkg::TWO_BYTE_LIMIT) begin
      cls = u2u8_pkg::CLS_TWO;
    end else if (u >= u2u8_pkg::HIGH_SURR_LO && u <= u2u8_pkg::HIGH_SURR_HI &&
                 !in_ch.is_last) begin
      cls = u2u8_pkg::CLS_HOLD;
    end else begin
      cls = u2u8_pkg::CLS_THREE;
    end
  end

  always_comb begin
    entry = '0;
    unique case (cls)
      u2u8_pkg::CLS_ONE: begin
        entry.bytes[0] = u[7:0];
        entry.count    = 3'd1;
      end
      u2u8_pkg::CLS_TWO: begin
        entry.bytes[0] = {3'b110, u[10:6]};
        entry.bytes[1] = {2'b10, u[5:0]};
        entry.count    = 3'd2;
      end
      u2u8_pkg::CLS_THREE: begin
        entry.bytes[0] = {4'b1110, u[15:12]};
        entry.bytes[1] = {2'b10, u[11:6]};
        entry.bytes[2] = {2'b10, u[5:0]};
        entry.count    = 3'd3;
      end
      u2u8_pkg::CLS_PAIR: begin
        entry.bytes[0] = {5'b11110, cp[20:18]};
        entry.bytes[1] = {2'b10, cp[17:12]};
        entry.bytes[2] = {2'b10, cp[11:6]};
        entry.bytes[3] = {2'b10, cp[5:0]};
        entry.count    = 3'd4;
      end
      u2u8_pkg::CLS_HOLD: begin
        entry.count = 3'd0;
      end
      default: begin
        entry.count = 3'd0;
      end
    endcase
    // terminator byte is already zero in the list
    if (in_ch.is_last) begin
      entry.count = entry.count + 3'd1;
    end
  end

  assign push_o.push  = accept && (entry.count != 3'd0);
  assign push_o.entry = entry;

  always_comb begin
    held_nxt      = held_r;
    held_unit_nxt = held_unit_r;
    if (accept) begin
      held_nxt = (cls == u2u8_pkg::CLS_HOLD);
      if (cls == u2u8_pkg::CLS_HOLD) begin
        held_unit_nxt = u[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_unit_r <= held_unit_nxt;
  end

endmodule

`default_nettype wire

/* rtl/u2u8_queue.sv */
// short fifo of byte lists between front and back
// depends on u2u8_pkg
`default_nettype none

module u2u8_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire u2u8_pkg::push_t  push_i,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output u2u8_pkg::entry_t      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u2u8_pkg::entry_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];
  assign do_push   = push_i.push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_i.entry;
    end
  end

endmodule

`default_nettype wire

/* rtl/u2u8_back.sv */
// back end: walks one byte list a byte per cycle, while the output is not stalled, into a registered output
// depends on u2u8_pkg and u2u8_out_if
`default_nettype none

module u2u8_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire u2u8_pkg::entry_t  q_head,
  output logic                   q_pop,
  u2u8_out_if.source             out_ch
);

  u2u8_pkg::entry_t              cur_r, cur_nxt;
  logic                          busy_r, busy_nxt;
  logic [u2u8_pkg::COUNT_W-1:0]  idx_r, idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_byte_r, out_byte_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          load_out, at_end;

  assign load_out = busy_r && (!out_valid_r || out_ch.ready);
  assign at_end   = (idx_r == cur_r.count - 3'd1);
  assign q_pop    = q_valid && (!busy_r || (load_out && at_end));

  always_comb begin
    cur_nxt       = cur_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_r.bytes[idx_r];
      out_last_nxt  = at_end;
      idx_nxt       = idx_r + 3'd1;
      if (at_end) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      cur_nxt  = q_head;
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = out_last_r;

endmodule

`default_nettype wire

/* tb/tb_utf16_to_utf8_encoder_unit.sv */
// testbench for utf16_to_utf8_encoder_unit: a directed table of code units, then random
// strings, with every output word checked against bytes typed in the table or a utf-8 predictor in this file
// depends on u2u8_if and the encoder rtl
module tb_utf16_to_utf8_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_ROWS    = 24;
  localparam int RAND_UNITS  = 206;
  localparam int N_PHASES    = 4;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } utf8_word_t;

  typedef logic [0:4][7:0] byte_list_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_last;
    logic        typed;
    logic [2:0]  n_exp;
    byte_list_t  bytes;
  } unit_row_t;

  // typed rows carry their expected bytes, the rest go through the predictor
  localparam unit_row_t DIR_TABLE [DIR_ROWS] = '{
    '{16'h0041, 1'b0, 1'b1, 3'd1, 40'h41_00_00_00_00},
    '{16'h0000, 1'b0, 1'b1, 3'd1, 40'h00_00_00_00_00},
    '{16'h007f, 1'b0, 1'b1, 3'd1, 40'h7f_00_00_00_00},
    '{16'h0080, 1'b0, 1'b1, 3'd2, 40'hc2_80_00_00_00},
    '{16'h07ff, 1'b0, 1'b1, 3'd2, 40'hdf_bf_00_00_00},
    '{16'h0800, 1'b0, 1'b1, 3'd3, 40'he0_a0_80_00_00},
    '{16'hffff, 1'b0, 1'b1, 3'd3, 40'hef_bf_bf_00_00},
    '{16'h0000, 1'b1, 1'b1, 3'd2, 40'h00_00_00_00_00},
    '{16'hd800, 1'b0, 1'b1, 3'd0, 40'h00_00_00_00_00},
    '{16'hdc00, 1'b0, 1'b1, 3'd4, 40'hf0_90_80_80_00},
    '{16'hdbff, 1'b0, 1'b1, 3'd0, 40'h00_00_00_00_00},
    '{16'hdfff, 1'b1, 1'b1, 3'd5, 40'hf4_8f_bf_bf_00},
    '{16'hd800, 1'b1, 1'b1, 3'd4, 40'hed_a0_80_00_00},
    '{16'h00e9, 1'b0, 1'b0, 3'd0, 40'h00_00_00_00_00},
    '{16'h20ac, 1'b0, 1'b0, 3'd0, 40'h00_00_00_00_00},
    '{16'hd83d, 1'b0, 1'b0, 3'd0, 40'h00_00_00_00_00},
    '{16'hde00, 1'b0, 1'b0, 3'd0, 40'h00_00_00_00_00},
    '{16'hd800, 1'b0, 1'b0, 3'd0, 40'h00_00_00_00_00},
    '{16'hd800, 1'b0, 1'b0, 3'd0, 40'h00_00_00_00_00},
    '{16'hdbff, 1'b0, 1'b0, 3'd0, 40'h00_00_00_00_00},
    '{16'h0041, 1'b1, 1'b0, 3'd0, 40'h00_00_00_00_00},
    '{16'hdc00, 1'b1, 1'b0, 3'd0, 40'h00_00_00_00_00},
    '{16'he000, 1'b0, 1'b0, 3'd0, 40'h00_00_00_00_00},
    '{16'h0061, 1'b1, 1'b0, 3'd0, 40'h00_00_00_00_00}
  };

  logic clk;
  logic rst_n;

  u2u8_in_if  in_bus();
  u2u8_out_if out_bus();

  utf8_word_t  exp_q [$];
  utf8_word_t  exp_w;
  utf8_word_t  got_w;
  logic        pred_held;
  logic [15:0] pred_unit;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_req_cnt   = 0;
  int          hold_done_cnt  = 0;
  int          n_units        = 0;
  int          n_words        = 0;
  int          n_errors       = 0;
  int          n_in_stalls    = 0;

  utf16_to_utf8_encoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  initial clk = 1'b0;
  always #4ns clk = ~clk;

  task automatic predict(input logic [15:0] cu, input logic lst,
                         output int n, output byte_list_t b);
    logic [31:0] u32;
    logic [31:0] cp;
    u32 = {16'h0000, cu};
    cp  = '0;
    n   = 0;
    b   = '0;
    if (pred_held) begin
      cp = ({16'h0000, pred_unit} << 10) + u32 + 32'h0001_0000
           - (32'h0000_d800 << 10) - 32'h0000_dc00;
      b[0] = 8'(32'hf0 | (cp >> 18));
      b[1] = 8'(32'h80 | ((cp >> 12) & 32'h3f));
      b[2] = 8'(32'h80 | ((cp >> 6) & 32'h3f));
      b[3] = 8'(32'h80 | (cp & 32'h3f));
      n = 4;
      pred_held = 1'b0;
      pred_unit = '0;
    end else if (u32 < 32'h80) begin
      b[0] = cu[7:0];
      n = 1;
    end else if (u32 < 32'h800) begin
      b[0] = 8'(32'hc0 | (u32 >> 6));
      b[1] = 8'(32'h80 | (u32 & 32'h3f));
      n = 2;
    end else if (u32 < 32'hd800 || u32 > 32'hdbff || lst) begin
      b[0] = 8'(32'he0 | (u32 >> 12));
      b[1] = 8'(32'h80 | ((u32 >> 6) & 32'h3f));
      b[2] = 8'(32'h80 | (u32 & 32'h3f));
      n = 3;
    end else begin
      pred_held = 1'b1;
      pred_unit = cu;
    end
    if (lst) begin
      b[n] = 8'h00;
      n = n + 1;
    end
  endtask

  task automatic push_expected(input int n, input byte_list_t b);
    utf8_word_t w;
    for (int k = 0; k < n; k++) begin
      w.value = b[k];
      w.last  = (k == n - 1);
      exp_q.push_back(w);
    end
  endtask

  // called at a falling edge, returns at the falling edge after the accepting edge
  task automatic send_unit(input logic [15:0] cu, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid     = 1'b1;
    in_bus.code_unit = cu;
    in_bus.is_last   = lst;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    n_units = n_units + 1;
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic apply_unit(input logic [15:0] cu, input logic lst, input logic typed,
                            input int n_typed, input byte_list_t b_typed);
    int         n;
    byte_list_t b;
    predict(cu, lst, n, b);
    if (typed) begin
      push_expected(n_typed, b_typed);
    end else begin
      push_expected(n, b);
    end
    send_unit(cu, lst);
  endtask

  task automatic wait_drain();
    while (exp_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_phase(input int p);
    case (p)
      1: begin
        send_idle_pct  = 63;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 63;
      end
      3: begin
        send_idle_pct  = 16;
        recv_stall_pct = 16;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  function automatic logic [15:0] rand_unit(input logic after_high);
    logic [15:0] cu;
    cu = 16'($urandom_range(127));
    if (after_high && $urandom_range(99) < 70) begin
      cu = 16'($urandom_range(16'hdfff, 16'hdc00));
    end else begin
      case ($urandom_range(9))
        0, 1, 2: cu = 16'($urandom_range(127));
        3: cu = 16'($urandom_range(16'h07ff, 16'h0080));
        4: cu = 16'($urandom_range(16'hd7ff, 16'h0800));
        5, 6: cu = 16'($urandom_range(16'hdbff, 16'hd800));
        7: cu = 16'($urandom_range(16'hdfff, 16'hdc00));
        8: cu = 16'($urandom_range(16'hffff, 16'he000));
        default: begin
          case ($urandom_range(5))
            0: cu = 16'h0000;
            1: cu = 16'h007f;
            2: cu = 16'h0080;
            3: cu = 16'h07ff;
            4: cu = 16'hffff;
            default: cu = 16'h0800;
          endcase
        end
      endcase
    end
    return cu;
  endfunction

  task automatic note_mismatch(input string what, input utf8_word_t e, input utf8_word_t g);
    n_errors = n_errors + 1;
    if (n_errors <= MAX_REPORTS) begin
      $display("mismatch (%0s) at %0t: expected byte %02h last %0b, got byte %02h last %0b",
               what, $time, e.value, e.last, g.value, g.last);
    end
  endtask

  // receiver, with a long hold counted here
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_done_cnt != hold_req_cnt) begin
        out_bus.ready = 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) begin
          @(negedge clk);
        end
        hold_done_cnt = hold_done_cnt + 1;
      end else begin
        out_bus.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && !in_bus.ready) begin
      n_in_stalls <= n_in_stalls + 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got_w.value = out_bus.out_byte;
      got_w.last  = out_bus.last_byte;
      n_words = n_words + 1;
      if (exp_q.size() == 0) begin
        note_mismatch("unexpected word", '0, got_w);
      end else begin
        exp_w = exp_q.pop_front();
        if (exp_w !== got_w) begin
          note_mismatch("wrong word", exp_w, got_w);
        end
      end
    end
  end

  initial begin
    int          n_this;
    logic [15:0] cu;
    logic        lst;
    in_bus.valid     = 1'b0;
    in_bus.code_unit = '0;
    in_bus.is_last   = 1'b0;
    pred_held        = 1'b0;
    pred_unit        = '0;
    rst_n            = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_phase(0);
    for (int i = 0; i < DIR_ROWS; i++) begin
      apply_unit(DIR_TABLE[i].code_unit, DIR_TABLE[i].is_last, DIR_TABLE[i].typed,
                 int'(DIR_TABLE[i].n_exp), DIR_TABLE[i].bytes);
    end
    wait_drain();

    for (int p = 0; p < N_PHASES; p++) begin
      set_phase(p);
      // long output stall while units keep coming
      if (p == 0) begin
        hold_req_cnt = hold_req_cnt + 1;
      end
      n_this = (p == N_PHASES - 1) ? RAND_UNITS - (N_PHASES - 1) * (RAND_UNITS / N_PHASES)
                                   : RAND_UNITS / N_PHASES;
      for (int i = 0; i < n_this; i++) begin
        cu  = rand_unit(pred_held);
        lst = ($urandom_range(5) == 0);
        apply_unit(cu, lst, 1'b0, 0, '0);
      end
      wait_drain();
    end

    set_phase(0);
    repeat (20) @(negedge clk);
    $display("sent %0d code units: directed table, then random strings under four idle patterns",
             n_units);
    $display("checked %0d output words; input held off %0d cycles incl. a long output stall",
             n_words, n_in_stalls);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("run limit reached with %0d words still expected", exp_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

/* utf16_to_utf8_encoder_unit.f */
rtl/u2u8_pkg.sv
rtl/u2u8_if.sv
rtl/u2u8_front.sv
rtl/u2u8_queue.sv
rtl/u2u8_back.sv
rtl/utf16_to_utf8_encoder_unit.sv
tb/tb_utf16_to_utf8_encoder_unit.sv
